### src/cts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cts_pkg: shared definitions for the task scheduler
// Sizes, task status codes, policy codes, register indexes, datapath
// operation codes and the command/status structs between controller and
// datapath.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  localparam int TIME_W = 32;
  localparam int SVC_W  = 16;
  localparam int PRI_W  = 8;
  localparam int ORD_W  = 32;
  localparam int POL_W  = 3;
  localparam int QNT_W  = 16;
  localparam int TCNT_W = 5;
  localparam int CMP_W  = (CNT_W > TCNT_W) ? CNT_W : TCNT_W;
  localparam int PROD_W = 2 * SVC_W;

  localparam int IN_W      = 40;
  localparam int OUT_W     = 48;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic signed [PRI_W-1:0] PRI_MIN = {1'b1, {(PRI_W-1){1'b0}}};
  localparam logic signed [PRI_W-1:0] PRI_MAX = {1'b0, {(PRI_W-1){1'b1}}};

  // Task status codes.
  localparam logic [2:0] ST_UNUSED  = 3'd0;
  localparam logic [2:0] ST_READY   = 3'd1;
  localparam logic [2:0] ST_BLOCKED = 3'd2;
  localparam logic [2:0] ST_RUNNING = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;
  localparam logic [2:0] ST_DONE_IO = 3'd5;

  // Dispatch policies; unlisted codes behave as round robin.
  localparam logic [POL_W-1:0] POL_RR   = 3'd0;
  localparam logic [POL_W-1:0] POL_SJF  = 3'd1;
  localparam logic [POL_W-1:0] POL_SRT  = 3'd2;
  localparam logic [POL_W-1:0] POL_GUAR = 3'd3;
  localparam logic [POL_W-1:0] POL_FB   = 3'd4;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 2'd2;

  typedef logic [4:0] op_t;

  localparam op_t OP_NOP      = 5'd0;
  localparam op_t OP_CHARGE   = 5'd1;
  localparam op_t OP_ARRIVE   = 5'd2;
  localparam op_t OP_QUANT    = 5'd3;
  localparam op_t OP_DUE      = 5'd4;
  localparam op_t OP_RLOAD    = 5'd5;
  localparam op_t OP_RCMP     = 5'd6;
  localparam op_t OP_RWRITE   = 5'd7;
  localparam op_t OP_APPLY    = 5'd8;
  localparam op_t OP_BUMP     = 5'd9;
  localparam op_t OP_IOREQ    = 5'd10;
  localparam op_t OP_FINISH   = 5'd11;
  localparam op_t OP_REQUEUE  = 5'd12;
  localparam op_t OP_DISP_A   = 5'd13;
  localparam op_t OP_DISP_B   = 5'd14;
  localparam op_t OP_DISP_END = 5'd15;
  localparam op_t OP_OUTPUT   = 5'd16;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] oi;
    logic [IDX_W-1:0] ii;
  } cmd_t;

  typedef struct packed {
    logic need;
    logic due_oi;
    logic multi_due;
    logic any_due;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

### src/cts_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cts_ctrl: tick sequencer
// Steps the datapath through the phases of one tick and the table scans.
// ----------------------------------------------------------------------------
module cts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cts_pkg::stat_t stat,
  output cts_pkg::cmd_t  cmd
);
  import cts_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_ARRIVE = 5'd1;
  localparam logic [4:0] S_QUANT  = 5'd2;
  localparam logic [4:0] S_DUE    = 5'd3;
  localparam logic [4:0] S_DSEL   = 5'd4;
  localparam logic [4:0] S_RLOAD  = 5'd5;
  localparam logic [4:0] S_RCMP   = 5'd6;
  localparam logic [4:0] S_RWRITE = 5'd7;
  localparam logic [4:0] S_APPLY  = 5'd8;
  localparam logic [4:0] S_BUMP   = 5'd9;
  localparam logic [4:0] S_IOREQ  = 5'd10;
  localparam logic [4:0] S_FINISH = 5'd11;
  localparam logic [4:0] S_REQ    = 5'd12;
  localparam logic [4:0] S_DA     = 5'd13;
  localparam logic [4:0] S_DB     = 5'd14;
  localparam logic [4:0] S_DEND   = 5'd15;
  localparam logic [4:0] S_OUT    = 5'd16;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_TASKS - 1);

  logic [4:0]       state, state_next;
  logic [IDX_W-1:0] oi, oi_next;
  logic [IDX_W-1:0] ii, ii_next;
  logic             ii_last, oi_last;

  assign ii_last = (ii == LAST);
  assign oi_last = (oi == LAST);

  always_comb begin
    state_next = state;
    oi_next    = oi;
    ii_next    = ii;
    in_ready   = 1'b0;
    cmd.op     = OP_NOP;
    cmd.oi     = oi;
    cmd.ii     = ii;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_CHARGE;
          state_next = S_ARRIVE;
        end
      end
      S_ARRIVE: begin
        cmd.op     = OP_ARRIVE;
        state_next = S_QUANT;
      end
      S_QUANT: begin
        cmd.op     = OP_QUANT;
        ii_next    = '0;
        state_next = S_DUE;
      end
      S_DUE: begin
        cmd.op = OP_DUE;
        if (ii_last) begin
          state_next = S_DSEL;
        end else begin
          ii_next = ii + 1'b1;
        end
      end
      S_DSEL: begin
        ii_next = '0;
        oi_next = '0;
        if (stat.multi_due) begin
          state_next = S_RLOAD;
        end else if (stat.any_due) begin
          state_next = S_APPLY;
        end else begin
          state_next = S_IOREQ;
        end
      end
      S_RLOAD: begin
        ii_next = '0;
        if (stat.due_oi) begin
          cmd.op     = OP_RLOAD;
          state_next = S_RCMP;
        end else if (oi_last) begin
          state_next = S_APPLY;
        end else begin
          oi_next = oi + 1'b1;
        end
      end
      S_RCMP: begin
        cmd.op = OP_RCMP;
        if (ii_last) begin
          state_next = S_RWRITE;
        end else begin
          ii_next = ii + 1'b1;
        end
      end
      S_RWRITE: begin
        cmd.op  = OP_RWRITE;
        ii_next = '0;
        if (oi_last) begin
          state_next = S_APPLY;
        end else begin
          oi_next    = oi + 1'b1;
          state_next = S_RLOAD;
        end
      end
      S_APPLY: begin
        cmd.op = OP_APPLY;
        if (ii_last) begin
          state_next = S_BUMP;
        end else begin
          ii_next = ii + 1'b1;
        end
      end
      S_BUMP: begin
        cmd.op     = OP_BUMP;
        state_next = S_IOREQ;
      end
      S_IOREQ: begin
        cmd.op     = OP_IOREQ;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.op     = OP_FINISH;
        state_next = S_REQ;
      end
      S_REQ: begin
        cmd.op  = OP_REQUEUE;
        ii_next = '0;
        if (stat.need) begin
          state_next = S_DA;
        end else begin
          state_next = S_OUT;
        end
      end
      S_DA: begin
        cmd.op     = OP_DISP_A;
        state_next = S_DB;
      end
      S_DB: begin
        cmd.op = OP_DISP_B;
        if (ii_last) begin
          state_next = S_DEND;
        end else begin
          ii_next    = ii + 1'b1;
          state_next = S_DA;
        end
      end
      S_DEND: begin
        cmd.op     = OP_DISP_END;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.op     = OP_OUTPUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      oi    <= '0;
      ii    <= '0;
    end else begin
      state <= state_next;
      oi    <= oi_next;
      ii    <= ii_next;
    end
  end

endmodule
`default_nettype wire

### src/cts_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cts_datapath: task table, counters and dispatch comparator
// Executes one operation per cycle as commanded by the sequencer.
// ----------------------------------------------------------------------------
module cts_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cts_pkg::CFG_W-1:0]     cfg_data,
  input  logic [cts_pkg::IN_W-1:0]      in_data,
  input  cts_pkg::cmd_t                 cmd,
  output cts_pkg::stat_t                stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cts_pkg::OUT_W-1:0]     out_data
);
  import cts_pkg::*;

  // Configuration.
  logic [POL_W-1:0]  policy;
  logic [QNT_W-1:0]  quantum;
  logic [TCNT_W-1:0] task_count;

  // Scheduler state.
  logic [TIME_W-1:0] cur_time;
  logic [QNT_W-1:0]  slice;
  logic [IDX_W-1:0]  rid;
  logic              rv;
  logic [ORD_W-1:0]  ocnt;
  logic [CNT_W-1:0]  created;
  logic [CNT_W-1:0]  nfin;

  // Task table.
  logic [2:0]              st   [MAX_TASKS];
  logic [SVC_W-1:0]        tgt  [MAX_TASKS];
  logic [SVC_W-1:0]        srv  [MAX_TASKS];
  logic [TIME_W-1:0]       arr  [MAX_TASKS];
  logic signed [PRI_W-1:0] pri  [MAX_TASKS];
  logic [TIME_W-1:0]       iod  [MAX_TASKS];
  logic [ORD_W-1:0]        ord  [MAX_TASKS];
  logic [IDX_W-1:0]        rk   [MAX_TASKS];
  logic [MAX_TASKS-1:0]    due;

  // Per-tick working registers.
  logic             new_task, io_request;
  logic [SVC_W-1:0] svc, dur;
  logic             need, keep, fin;
  logic [IDX_W-1:0] fin_id;
  logic [TIME_W-1:0] wall;
  logic [CNT_W-1:0] dcount;
  logic [ORD_W-1:0] age_i;
  logic [IDX_W-1:0] rank;

  // Dispatch candidate and best so far.
  logic                    found, cand_ok;
  logic [IDX_W-1:0]        cand_idx, best_idx;
  logic [SVC_W-1:0]        cand_tgt, cand_srv, best_tgt, best_srv;
  logic signed [SVC_W:0]   cand_rem, best_rem;
  logic signed [PRI_W-1:0] cand_pri, best_pri;
  logic [ORD_W-1:0]        cand_age, best_age;
  logic [PROD_W-1:0]       p1, p2;

  // Table read port, one address per cycle.
  logic [IDX_W-1:0]        rd_idx;
  logic [2:0]              r_st;
  logic [SVC_W-1:0]        r_tgt, r_srv;
  logic [TIME_W-1:0]       r_arr, r_iod;
  logic signed [PRI_W-1:0] r_pri;
  logic [ORD_W-1:0]        r_ord, r_age;

  logic [IDX_W-1:0] new_idx;
  logic             arrive_ok, due_hit, quant_hit, finish_hit;
  logic [SVC_W-1:0] dur_eff;
  logic             lt, eq, better;

  always_comb begin
    case (cmd.op)
      OP_RLOAD, OP_RWRITE:                    rd_idx = cmd.oi;
      OP_DUE, OP_RCMP, OP_APPLY, OP_DISP_A:   rd_idx = cmd.ii;
      default:                                rd_idx = rid;
    endcase
  end

  assign r_st  = st[rd_idx];
  assign r_tgt = tgt[rd_idx];
  assign r_srv = srv[rd_idx];
  assign r_arr = arr[rd_idx];
  assign r_pri = pri[rd_idx];
  assign r_iod = iod[rd_idx];
  assign r_ord = ord[rd_idx];
  assign r_age = r_ord - ocnt;

  assign new_idx    = created[IDX_W-1:0];
  assign arrive_ok  = new_task && (created < CNT_W'(MAX_TASKS));
  assign due_hit    = (r_iod == cur_time);
  assign quant_hit  = (slice == quantum);
  assign finish_hit = rv && (r_srv == r_tgt);
  assign dur_eff    = (dur == '0) ? SVC_W'(1) : dur;

  // Policy comparison of the registered candidate against the best so far.
  always_comb begin
    case (policy)
      POL_SJF: begin
        lt = cand_tgt < best_tgt;
        eq = cand_tgt == best_tgt;
      end
      POL_SRT: begin
        lt = cand_rem < best_rem;
        eq = cand_rem == best_rem;
      end
      POL_GUAR: begin
        lt = p1 < p2;
        eq = p1 == p2;
      end
      POL_FB: begin
        lt = cand_pri > best_pri;
        eq = cand_pri == best_pri;
      end
      default: begin
        lt = 1'b0;
        eq = 1'b1;
      end
    endcase
    better = lt || (eq && (cand_age < best_age));
  end

  assign stat.need      = need;
  assign stat.due_oi    = due[cmd.oi];
  assign stat.multi_due = dcount > CNT_W'(1);
  assign stat.any_due   = dcount != '0;
  assign stat.out_free  = !out_valid || out_ready;

  // Registers with a defined reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      policy     <= POL_RR;
      quantum    <= QNT_W'(10);
      task_count <= TCNT_W'(16);
      cur_time   <= '0;
      slice      <= '0;
      rid        <= '0;
      rv         <= 1'b0;
      ocnt       <= '0;
      created    <= '0;
      nfin       <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        st[i] <= ST_UNUSED;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_POLICY:     policy     <= cfg_data[POL_W-1:0];
          CFG_QUANTUM:    quantum    <= cfg_data[QNT_W-1:0];
          CFG_TASK_COUNT: task_count <= cfg_data[TCNT_W-1:0];
          default:        ;
        endcase
      end
      if (cmd.op == OP_OUTPUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_CHARGE: begin
          cur_time <= cur_time + 1'b1;
          slice    <= slice + 1'b1;
        end
        OP_ARRIVE: begin
          if (arrive_ok) begin
            st[new_idx] <= ST_READY;
            ocnt        <= ocnt + 1'b1;
            created     <= created + 1'b1;
          end
        end
        OP_DUE: begin
          if (due_hit && r_st == ST_DONE_IO) begin
            st[rd_idx] <= ST_DONE;
          end
        end
        OP_APPLY: begin
          if (due[rd_idx]) begin
            st[rd_idx] <= ST_READY;
          end
        end
        OP_BUMP: begin
          ocnt <= ocnt + ORD_W'(dcount);
        end
        OP_IOREQ: begin
          if (io_request && rv) begin
            st[rid] <= ST_BLOCKED;
            ocnt    <= ocnt + 1'b1;
          end
        end
        OP_FINISH: begin
          if (finish_hit) begin
            st[rid] <= (r_st == ST_BLOCKED) ? ST_DONE_IO : ST_DONE;
            nfin    <= nfin + 1'b1;
          end
        end
        OP_REQUEUE: begin
          if (need && rv && keep) begin
            st[rid] <= ST_READY;
            ocnt    <= ocnt + 1'b1;
          end
        end
        OP_DISP_END: begin
          slice <= '0;
          if (found) begin
            st[best_idx] <= ST_RUNNING;
            rid          <= best_idx;
            rv           <= 1'b1;
          end else begin
            rid <= '0;
            rv  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload and per-tick working registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CHARGE: begin
        new_task   <= in_data[0];
        svc        <= in_data[16:1];
        io_request <= in_data[17];
        dur        <= in_data[33:18];
        need       <= 1'b0;
        keep       <= 1'b1;
        fin        <= 1'b0;
        fin_id     <= '0;
        wall       <= '0;
        if (rv) begin
          srv[rid] <= r_srv + 1'b1;
        end
      end
      OP_ARRIVE: begin
        if (arrive_ok) begin
          tgt[new_idx] <= svc;
          srv[new_idx] <= '0;
          arr[new_idx] <= cur_time;
          pri[new_idx] <= '0;
          iod[new_idx] <= '0;
          ord[new_idx] <= ocnt;
          need         <= 1'b1;
        end
      end
      OP_QUANT: begin
        dcount <= '0;
        if (quant_hit) begin
          need <= 1'b1;
          if (rv && r_pri != PRI_MIN) begin
            pri[rid] <= r_pri - $signed(PRI_W'(1));
          end
        end
      end
      OP_DUE: begin
        due[rd_idx] <= due_hit && (r_st == ST_BLOCKED);
        rk[rd_idx]  <= '0;
        if (due_hit && r_st == ST_BLOCKED) begin
          dcount <= dcount + 1'b1;
        end
        if (due_hit && r_st == ST_DONE_IO) begin
          need <= 1'b1;
        end
      end
      OP_RLOAD: begin
        age_i <= r_age;
        rank  <= '0;
      end
      OP_RCMP: begin
        if (due[rd_idx] && r_age < age_i) begin
          rank <= rank + 1'b1;
        end
      end
      OP_RWRITE: begin
        rk[cmd.oi] <= rank;
      end
      OP_APPLY: begin
        if (due[rd_idx]) begin
          ord[rd_idx] <= ocnt + ORD_W'(rk[rd_idx]);
          need        <= 1'b1;
        end
      end
      OP_IOREQ: begin
        if (io_request && rv) begin
          if (slice < quantum && r_pri != PRI_MAX) begin
            pri[rid] <= r_pri + $signed(PRI_W'(1));
          end
          iod[rid] <= cur_time + TIME_W'(dur_eff);
          ord[rid] <= ocnt;
          need     <= 1'b1;
          keep     <= 1'b0;
        end
      end
      OP_FINISH: begin
        if (finish_hit) begin
          fin    <= 1'b1;
          fin_id <= rid;
          wall   <= cur_time - r_arr;
          need   <= 1'b1;
          keep   <= 1'b0;
        end
      end
      OP_REQUEUE: begin
        found <= 1'b0;
        if (need && rv && keep) begin
          ord[rid] <= ocnt;
        end
      end
      OP_DISP_A: begin
        cand_ok  <= (r_st == ST_READY);
        cand_idx <= rd_idx;
        cand_tgt <= r_tgt;
        cand_srv <= r_srv;
        cand_rem <= $signed({1'b0, r_tgt}) - $signed({1'b0, r_srv});
        cand_pri <= r_pri;
        cand_age <= r_age;
        p1       <= PROD_W'(r_srv) * PROD_W'(best_tgt);
        p2       <= PROD_W'(best_srv) * PROD_W'(r_tgt);
      end
      OP_DISP_B: begin
        if (cand_ok && (!found || better)) begin
          found    <= 1'b1;
          best_idx <= cand_idx;
          best_tgt <= cand_tgt;
          best_srv <= cand_srv;
          best_rem <= cand_rem;
          best_pri <= cand_pri;
          best_age <= cand_age;
        end
      end
      OP_OUTPUT: begin
        out_data <= {5'd0,
                     CMP_W'(nfin) >= CMP_W'(task_count),
                     wall,
                     4'(fin_id),
                     fin,
                     !rv,
                     rv ? 4'(rid) : 4'd0};
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### src/cpu_task_scheduler_five_policy_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_task_scheduler_five_policy_top: tick-driven task scheduler
// One input beat is one scheduler tick; one output beat reports the outcome.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Beat contents
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | one tick: arrival, service, I/O request, duration
//  m_axis   | out       | running task, idle, completion, wall time, done
//  cfg      | in        | register write: policy, quantum, task count
//
// The output beat follows the sequencer's walk over the sixteen-entry task
// table: an I/O due scan of every entry, then a dispatch pass that loads and
// compares each entry. Dispatch is skipped when nothing forces a reschedule.
// A single I/O completion adds an apply pass and a step that advances the
// order counter; several simultaneous completions also add a ranking scan
// with a comparison walk over the table for each due task.
// A new input beat is taken in the cycle after the output register is loaded.
// Reset is synchronous; the table needs no clearing pass. A stalled output
// beat is held in its register; the next tick is processed meanwhile and only
// waits at the very end for the output register to free up.
//
module cpu_task_scheduler_five_policy_top (
  input  logic                          clk,
  input  logic                          rst,
  // Register write port.
  input  logic                          cfg_we,
  input  logic [cts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cts_pkg::CFG_W-1:0]     cfg_data,
  // Tick input.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [0] new_task, [16:1] new_task_service, [17] io_request,
  // [33:18] io_duration, [39:34] zero
  input  logic [cts_pkg::IN_W-1:0]      s_axis_tdata,
  // Tick result.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [3:0] running_task, [4] cpu_idle, [5] finished, [9:6] finished_task,
  // [41:10] finished_wall, [42] all_done, [47:43] zero
  output logic [cts_pkg::OUT_W-1:0]     m_axis_tdata
);
  import cts_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // The sequencer owns the input handshake; the datapath latches the beat on
  // the same edge at which it is accepted.
  cts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the task table, the counters, the configuration and
  // the output register.
  cts_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
`default_nettype wire

### src/cts_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cts_checker: port-level checks for the task scheduler
// Watches the top level's stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
module cts_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [cts_pkg::IN_W-1:0]  s_axis_tdata,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [cts_pkg::OUT_W-1:0] m_axis_tdata
);
  import cts_pkg::*;

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // An idle CPU reports task zero as running.
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3:0] == 4'd0)
    else $error("idle CPU reports a running task");

  // Without a completion, the completion fields are zero.
  a_fin_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[5] |->
      m_axis_tdata[9:6] == 4'd0 && m_axis_tdata[41:10] == 32'd0)
    else $error("completion fields set without a completion");

  // Straight after reset the block takes a tick and shows no result.
  a_reset_ready: assert property (@(posedge clk)
    $past(rst) |-> s_axis_tready && !m_axis_tvalid)
    else $error("block not ready after reset");

endmodule

bind cpu_task_scheduler_five_policy_top cts_checker u_cts_checker (.*);
`default_nettype wire
